// ----- src/fci_pkg.sv -----
package fci_pkg;

    localparam int MAX_POINTS_DEF = 6;

    localparam int TEMP_W     = 16;
    localparam int RPM_W      = 16;
    localparam int POINT_W    = 32;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 2 * RPM_W;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE  = 3'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic             interp;
        logic [RPM_W-1:0] rpm;
        logic [RPM_W-1:0] hi_rpm;
        logic [RPM_W-1:0] dx;
        logic [RPM_W-1:0] span;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_SUM
    } t_bk_state;

    typedef struct packed {
        logic idle;
        logic finishing;
    } t_bk_status;

endpackage

// ----- src/fci_front.sv -----
module fci_front #(
    parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
    input  logic signed [fci_pkg::TEMP_W-1:0]  i_temperature,
    input  logic        [fci_pkg::COUNT_W-1:0] i_point_count,
    input  logic        [fci_pkg::POINT_W-1:0] i_point [MAX_POINTS],
    output fci_pkg::t_job                      o_job
);

    logic        [fci_pkg::COUNT_W-1:0] used;
    logic signed [fci_pkg::TEMP_W-1:0]  first_t;
    logic signed [fci_pkg::TEMP_W-1:0]  last_t;
    logic        [fci_pkg::RPM_W-1:0]   last_r;
    logic signed [fci_pkg::TEMP_W-1:0]  hi_t;
    logic signed [fci_pkg::TEMP_W-1:0]  lo_t;
    logic        [fci_pkg::RPM_W-1:0]   hi_r;
    logic        [fci_pkg::RPM_W-1:0]   lo_r;
    logic                               found;
    logic        [fci_pkg::TEMP_W:0]    span;
    logic        [fci_pkg::TEMP_W:0]    dx;

    assign used = (i_point_count > fci_pkg::COUNT_W'(MAX_POINTS))
                ? fci_pkg::COUNT_W'(MAX_POINTS) : i_point_count;

    assign first_t = $signed(i_point[0][31:16]);

    always_comb begin
        last_t = first_t;
        last_r = i_point[0][15:0];
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (fci_pkg::COUNT_W'(k + 1) == used) begin
                last_t = $signed(i_point[k][31:16]);
                last_r = i_point[k][15:0];
            end
        end
    end

    // first segment end at or above the sample
    always_comb begin
        found = 1'b0;
        hi_t  = last_t;
        hi_r  = last_r;
        lo_t  = first_t;
        lo_r  = i_point[0][15:0];
        for (int k = 1; k < MAX_POINTS; k++) begin
            if (!found && (fci_pkg::COUNT_W'(k) < used)
                && (i_temperature <= $signed(i_point[k][31:16]))) begin
                found = 1'b1;
                hi_t  = $signed(i_point[k][31:16]);
                hi_r  = i_point[k][15:0];
                lo_t  = $signed(i_point[k-1][31:16]);
                lo_r  = i_point[k-1][15:0];
            end
        end
    end

    assign span = {hi_t[15], hi_t} - {lo_t[15], lo_t};
    assign dx   = {i_temperature[15], i_temperature} - {lo_t[15], lo_t};

    always_comb begin
        o_job = '0;
        if (used == '0) begin
            o_job.rpm = '0;
        end else if (i_temperature <= first_t) begin
            o_job.rpm = i_point[0][15:0];
        end else if (i_temperature >= last_t) begin
            o_job.rpm = last_r;
        end else if (!found) begin
            o_job.rpm = last_r;
        end else if (span[fci_pkg::TEMP_W] || (span == '0)) begin
            o_job.rpm = hi_r;
        end else begin
            o_job.interp = 1'b1;
            o_job.rpm    = lo_r;
            o_job.hi_rpm = hi_r;
            o_job.dx     = dx[fci_pkg::TEMP_W-1:0];
            o_job.span   = span[fci_pkg::TEMP_W-1:0];
        end
    end

endmodule

// ----- src/fci_queue.sv -----
module fci_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  fci_pkg::t_job              i_job,
    input  logic                       i_pop,
    output fci_pkg::t_job              o_job,
    output logic                       o_valid,
    output logic                       o_full,
    output logic [fci_pkg::QCNT_W-1:0] o_count
);

    fci_pkg::t_job                    r_entry [fci_pkg::QUEUE_DEPTH];
    logic [fci_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [fci_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [fci_pkg::QCNT_W-1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_entry[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == fci_pkg::QCNT_W'(fci_pkg::QUEUE_DEPTH));
    assign o_count = r_count;

endmodule

// ----- src/fci_back.sv -----
module fci_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  fci_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [fci_pkg::RPM_W-1:0] o_fan_rpm,
    output fci_pkg::t_bk_status       o_status
);

    fci_pkg::t_bk_state r_state;
    fci_pkg::t_bk_state n_state;

    logic [fci_pkg::RPM_W-1:0]     r_lo;
    logic [fci_pkg::RPM_W-1:0]     r_span;
    logic [fci_pkg::RPM_W-1:0]     r_dx;
    logic [fci_pkg::RPM_W-1:0]     r_mag;
    logic                          r_neg;
    logic [fci_pkg::RPM_W-1:0]     r_rem;
    logic [fci_pkg::RPM_W-1:0]     r_quo;
    logic [fci_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_valid;
    logic [fci_pkg::RPM_W-1:0]     r_fan_rpm;

    logic [fci_pkg::RPM_W:0]       diff;
    logic [fci_pkg::RPM_W:0]       neg_diff;
    logic [fci_pkg::PROD_W-1:0]    prod;
    logic [fci_pkg::RPM_W:0]       trial;
    logic [fci_pkg::RPM_W:0]       trial_sub;
    logic                          q_bit;

    assign diff     = {1'b0, i_job.hi_rpm} - {1'b0, i_job.rpm};
    assign neg_diff = -diff;
    assign prod     = r_dx * r_mag;

    // restoring step, remainder always below span
    assign trial     = {r_rem, r_quo[fci_pkg::RPM_W-1]};
    assign trial_sub = trial - {1'b0, r_span};
    assign q_bit     = (trial >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fci_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            fci_pkg::BK_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_job.interp) begin
                        n_state = fci_pkg::BK_MUL;
                    end
                end
            end
            fci_pkg::BK_MUL: begin
                n_state = fci_pkg::BK_DIV;
            end
            fci_pkg::BK_DIV: begin
                if (r_cnt == fci_pkg::DIV_CNT_W'(fci_pkg::DIV_STEPS - 1)) begin
                    n_state = fci_pkg::BK_SUM;
                end
            end
            fci_pkg::BK_SUM: begin
                n_state = fci_pkg::BK_IDLE;
            end
            default: begin
                n_state = fci_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (o_pop && !i_job.interp) || (r_state == fci_pkg::BK_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fci_pkg::BK_IDLE: begin
                if (o_pop) begin
                    r_fan_rpm <= i_job.rpm;
                    r_lo      <= i_job.rpm;
                    r_span    <= i_job.span;
                    r_dx      <= i_job.dx;
                    r_neg     <= diff[fci_pkg::RPM_W];
                    r_mag     <= diff[fci_pkg::RPM_W] ? neg_diff[fci_pkg::RPM_W-1:0]
                                                      : diff[fci_pkg::RPM_W-1:0];
                end
            end
            fci_pkg::BK_MUL: begin
                r_rem <= prod[fci_pkg::PROD_W-1:fci_pkg::RPM_W];
                r_quo <= prod[fci_pkg::RPM_W-1:0];
                r_cnt <= '0;
            end
            fci_pkg::BK_DIV: begin
                r_rem <= q_bit ? trial_sub[fci_pkg::RPM_W-1:0] : trial[fci_pkg::RPM_W-1:0];
                r_quo <= {r_quo[fci_pkg::RPM_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
            end
            fci_pkg::BK_SUM: begin
                r_fan_rpm <= r_neg ? (r_lo - r_quo) : (r_lo + r_quo);
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_valid            = r_valid;
    assign o_fan_rpm          = r_fan_rpm;
    assign o_status.idle      = (r_state == fci_pkg::BK_IDLE);
    assign o_status.finishing = (r_state == fci_pkg::BK_SUM);

endmodule

// ----- src/fan_curve_interpolator.sv -----
// An accepted sample is registered in the job queue; the back end pops it and
//   registers a clamped (end-of-curve, flat-segment or empty-curve) result, or
//   runs MUL, the 16-step serial divider and SUM for an interpolated one,
//   then takes the next; clamped samples drain at one per cycle when idle.
// busy rises while the two-entry job queue is full; o_valid pulses for one cycle.
// Reset (synchronous, active low) clears the curve, the queue and the back end.
module fan_curve_interpolator #(
    parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fci_pkg::TEMP_W-1:0]   i_temperature,
    input  logic                                i_cfg_we,
    input  logic        [fci_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [fci_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_valid,
    output logic        [fci_pkg::RPM_W-1:0]    o_fan_rpm
);

    logic [fci_pkg::COUNT_W-1:0] r_point_count;
    logic [fci_pkg::POINT_W-1:0] r_point [MAX_POINTS];

    fci_pkg::t_job               front_job;
    fci_pkg::t_job               queue_job;
    logic                        push;
    logic                        pop;
    logic                        q_valid;
    logic                        q_full;
    logic [fci_pkg::QCNT_W-1:0]  q_count;
    fci_pkg::t_bk_status         bk_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_point[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fci_pkg::REG_POINT_COUNT) begin
                r_point_count <= i_cfg_data[fci_pkg::COUNT_W-1:0];
            end
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (i_cfg_idx == fci_pkg::REG_POINT_BASE + fci_pkg::CFG_IDX_W'(k)) begin
                    r_point[k] <= i_cfg_data[fci_pkg::POINT_W-1:0];
                end
            end
        end
    end

    assign busy = q_full;
    assign push = start && !busy;

    fci_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_temperature (i_temperature),
        .i_point_count (r_point_count),
        .i_point       (r_point),
        .o_job         (front_job)
    );

    fci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count)
    );

    fci_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_job     (queue_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_fan_rpm (o_fan_rpm),
        .o_status  (bk_status)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= fci_pkg::QCNT_W'(fci_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond depth");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (bk_status.idle && q_valid))
        else $error("queue popped while back end busy or queue empty");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(pop) || $past(bk_status.finishing)))
        else $error("result strobe without a finished job");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe straight after reset");

endmodule
